// ----- rtl/mt4_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix transform unit.
package mt4_pkg;

    localparam int DIM           = 4;
    localparam int ELEM_W        = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    // four full-range products need two guard bits
    localparam int SUM_W         = PROD_W + 2;
    // lowest sum bit that must equal the sign for the shifted value to fit
    localparam int FIT_LSB       = ELEM_W - 1 + FRACTION_BITS;
    localparam int UPPER_W       = SUM_W - FIT_LSB;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int ROWS_W        = 3;

    typedef logic signed [ELEM_W-1:0] elem_t;

    localparam elem_t SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam elem_t SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_XFORM   = 2'd1,
        CMD_COMPOSE = 2'd2
    } cmd_t;

    // register word select (paddr[2])
    localparam logic REG_ROWS_IN_USE = 1'b0;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd4;
    localparam logic [ROWS_W-1:0] ROWS_THREE = 3'd3;

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } lane_ctl_t;

endpackage

// ----- rtl/mt4_lane.sv -----
// One dot-product lane: four registered products, registered sum, shift and clip.
module mt4_lane (
    input  logic                  aclk,
    input  mt4_pkg::lane_ctl_t    ctl,
    input  mt4_pkg::elem_t        coef [mt4_pkg::DIM],
    input  mt4_pkg::elem_t        vec  [mt4_pkg::DIM],
    output mt4_pkg::elem_t        result,
    output logic                  clip
);

    logic signed [mt4_pkg::PROD_W-1:0]  prod_reg  [mt4_pkg::DIM];
    logic signed [mt4_pkg::PROD_W-1:0]  prod_next [mt4_pkg::DIM];
    logic signed [mt4_pkg::SUM_W-1:0]   sum_reg;
    logic signed [mt4_pkg::SUM_W-1:0]   sum_next;
    logic [mt4_pkg::UPPER_W-1:0]        upper;
    logic                               in_range;

    always_comb begin
        for (int k = 0; k < mt4_pkg::DIM; k++) begin
            prod_next[k] = mt4_pkg::PROD_W'(coef[k]) * mt4_pkg::PROD_W'(vec[k]);
        end
    end

    always_comb begin
        sum_next = '0;
        for (int k = 0; k < mt4_pkg::DIM; k++) begin
            sum_next = sum_next + mt4_pkg::SUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_reg <= prod_next;
        end
        if (ctl.load_sum) begin
            sum_reg <= sum_next;
        end
    end

    // arithmetic shift then fit check: all bits above the kept field match the sign
    assign upper    = sum_reg[mt4_pkg::SUM_W-1:mt4_pkg::FIT_LSB];
    assign in_range = (&upper) | ~(|upper);
    assign clip     = ~in_range;

    always_comb begin
        if (in_range) begin
            result = sum_reg[mt4_pkg::FIT_LSB:mt4_pkg::FRACTION_BITS];
        end else if (sum_reg[mt4_pkg::SUM_W-1]) begin
            result = mt4_pkg::SAT_MIN;
        end else begin
            result = mt4_pkg::SAT_MAX;
        end
    end

endmodule

// ----- rtl/mt4_merge.sv -----
// Merge stage: collects lane results, applies three-row masking to transforms, ORs clip flags.
module mt4_merge (
    input  logic                  aclk,
    input  logic                  load_out,
    input  logic                  xform,
    input  logic                  three_row,
    input  mt4_pkg::elem_t        lane_result [mt4_pkg::DIM],
    input  logic [mt4_pkg::DIM-1:0] lane_clip,
    output mt4_pkg::elem_t        out_data [mt4_pkg::DIM],
    output logic                  out_sat
);

    mt4_pkg::elem_t             out_reg  [mt4_pkg::DIM];
    mt4_pkg::elem_t             out_next [mt4_pkg::DIM];
    logic                       sat_reg;
    logic                       sat_next;
    logic [mt4_pkg::DIM-1:0]    clip_used;
    logic                       mask_last;

    assign mask_last = xform && three_row;

    always_comb begin
        out_next  = lane_result;
        clip_used = lane_clip;
        if (mask_last) begin
            out_next[mt4_pkg::DIM-1]  = '0;
            clip_used[mt4_pkg::DIM-1] = 1'b0;
        end
        sat_next = |clip_used;
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign out_data = out_reg;
    assign out_sat  = sat_reg;

`ifndef SYNTHESIS
    a_three_row_zero: assert property (@(posedge aclk)
        load_out && mask_last |=> out_reg[mt4_pkg::DIM-1] == '0)
        else $error("element 3 not zeroed in three-row transform");

    a_sat_extreme: assert property (@(posedge aclk)
        load_out |=> !sat_reg
            || out_reg[0] == mt4_pkg::SAT_MAX || out_reg[0] == mt4_pkg::SAT_MIN
            || out_reg[1] == mt4_pkg::SAT_MAX || out_reg[1] == mt4_pkg::SAT_MIN
            || out_reg[2] == mt4_pkg::SAT_MAX || out_reg[2] == mt4_pkg::SAT_MIN
            || out_reg[3] == mt4_pkg::SAT_MAX || out_reg[3] == mt4_pkg::SAT_MIN)
        else $error("saturated flag set with no clipped element");
`endif

endmodule

// ----- rtl/matrix_transform_4x4.sv -----
// Pipeline: an accepted transform/compose word passes the product, sum and merge
// registers to m_tvalid. Throughput: one word per cycle unless m_tready stalls the
// pipeline; load words finish in their accept cycle and are seen by the very next word.
// Reset (aresetn low, synchronous): matrix cleared to zero, rows_in_use = 4,
// pipeline emptied.
module matrix_transform_4x4 (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: elem_0, elem_1, elem_2, elem_3 (32 bits each)
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [4*mt4_pkg::ELEM_W-1:0]      s_tdata,
    // s_tuser: cmd [1:0], row_index [3:2]
    input  logic [3:0]                        s_tuser,
    // m_tdata: out_0, out_1, out_2, out_3 (32 bits each)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*mt4_pkg::ELEM_W-1:0]      m_tdata,
    // m_tuser: saturated
    output logic                              m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mt4_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mt4_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mt4_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    mt4_pkg::elem_t               mat_reg  [mt4_pkg::DIM][mt4_pkg::DIM];
    mt4_pkg::elem_t               elem_in  [mt4_pkg::DIM];
    mt4_pkg::elem_t               coef     [mt4_pkg::DIM][mt4_pkg::DIM];
    mt4_pkg::elem_t               lane_result [mt4_pkg::DIM];
    mt4_pkg::elem_t               out_data [mt4_pkg::DIM];
    logic [mt4_pkg::DIM-1:0]      lane_clip;
    logic [mt4_pkg::ROWS_W-1:0]   rows_reg;
    logic [1:0]                   row_sel;
    mt4_pkg::cmd_t                cmd_in;
    mt4_pkg::lane_ctl_t           lane_ctl;
    logic                         acc_in;
    logic                         is_mul;
    logic                         is_load;
    logic                         cfg_wr;
    logic                         prod_valid_reg;
    logic                         sum_valid_reg;
    logic                         out_valid_reg;
    logic                         prod_xf_reg;
    logic                         sum_xf_reg;
    logic                         en_out;
    logic                         en_sum;
    logic                         en_prod;
    logic                         out_sat;

    assign cmd_in  = mt4_pkg::cmd_t'(s_tuser[1:0]);
    assign row_sel = s_tuser[3:2];

    always_comb begin
        for (int k = 0; k < mt4_pkg::DIM; k++) begin
            elem_in[k] = s_tdata[k*mt4_pkg::ELEM_W +: mt4_pkg::ELEM_W];
        end
    end

    // ---- handshake and pipeline valids (stages collapse bubbles) ----
    assign en_out   = !out_valid_reg || m_tready;
    assign en_sum   = !sum_valid_reg || en_out;
    assign en_prod  = !prod_valid_reg || en_sum;
    assign s_tready = en_prod;
    assign acc_in   = s_tvalid && s_tready;

    always_comb begin
        is_mul  = 1'b0;
        is_load = 1'b0;
        unique case (cmd_in) inside
            mt4_pkg::CMD_LOAD:                         is_load = acc_in;
            mt4_pkg::CMD_XFORM, mt4_pkg::CMD_COMPOSE:  is_mul  = acc_in;
            default: ;
        endcase
    end

    assign lane_ctl.load_prod = is_mul;
    assign lane_ctl.load_sum  = en_sum && prod_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (en_prod) begin
                prod_valid_reg <= is_mul;
            end
            if (en_sum) begin
                sum_valid_reg <= prod_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_mul) begin
            prod_xf_reg <= (cmd_in == mt4_pkg::CMD_XFORM);
        end
        if (lane_ctl.load_sum) begin
            sum_xf_reg <= prod_xf_reg;
        end
    end

    // ---- matrix store ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < mt4_pkg::DIM; r++) begin
                for (int c = 0; c < mt4_pkg::DIM; c++) begin
                    mat_reg[r][c] <= '0;
                end
            end
        end else if (is_load) begin
            mat_reg[row_sel] <= elem_in;
        end
    end

    // transform uses rows of S, compose uses columns
    always_comb begin
        for (int i = 0; i < mt4_pkg::DIM; i++) begin
            for (int k = 0; k < mt4_pkg::DIM; k++) begin
                coef[i][k] = (cmd_in == mt4_pkg::CMD_XFORM) ? mat_reg[i][k] : mat_reg[k][i];
            end
        end
    end

    for (genvar g = 0; g < mt4_pkg::DIM; g++) begin : g_lane
        mt4_lane u_lane (
            .aclk   (aclk),
            .ctl    (lane_ctl),
            .coef   (coef[g]),
            .vec    (elem_in),
            .result (lane_result[g]),
            .clip   (lane_clip[g])
        );
    end

    mt4_merge u_merge (
        .aclk        (aclk),
        .load_out    (en_out && sum_valid_reg),
        .xform       (sum_xf_reg),
        .three_row   (rows_reg == mt4_pkg::ROWS_THREE),
        .lane_result (lane_result),
        .lane_clip   (lane_clip),
        .out_data    (out_data),
        .out_sat     (out_sat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data[3], out_data[2], out_data[1], out_data[0]};
    assign m_tuser  = out_sat;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= mt4_pkg::ROWS_RESET;
        end else if (cfg_wr && paddr[2] == mt4_pkg::REG_ROWS_IN_USE) begin
            rows_reg <= pwdata[mt4_pkg::ROWS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mt4_pkg::REG_ROWS_IN_USE) begin
            prdata = mt4_pkg::APB_DATA_W'(rows_reg);
        end
    end

`ifndef SYNTHESIS
    a_load_written: assert property (@(posedge aclk) disable iff (!aresetn)
        is_load |=> mat_reg[$past(row_sel)][0] == $past(elem_in[0])
                 && mat_reg[$past(row_sel)][3] == $past(elem_in[3]))
        else $error("load word did not reach the matrix row");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid_reg && sum_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("word accepted into a full pipeline");
`endif

endmodule
